// ===== rtl/tridiagonal_solver_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the tridiagonal solver
// ---------------------------------------------------------------------------
`ifndef TRIDIAGONAL_SOLVER_CORE_ASSERT_SVH
`define TRIDIAGONAL_SOLVER_CORE_ASSERT_SVH

// same-cycle implication
`define TDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tds_pkg.sv =====
// ---------------------------------------------------------------------------
// tds_pkg
// Shared types, defaults and helpers of the tridiagonal solver.
// ---------------------------------------------------------------------------
`default_nettype none

package tds_pkg;

  localparam int MAX_ROWS_DEF  = 64;
  localparam int FRAC_BITS_DEF = 16;

  // one matrix row
  typedef struct packed {
    logic signed [31:0] sub_diag;
    logic signed [31:0] main_diag;
    logic signed [31:0] super_diag;
    logic signed [31:0] rhs;
    logic               last_row;
  } in_word_t;

  // one solved unknown
  typedef struct packed {
    logic signed [31:0] solution;
    logic [5:0]         row_index;
    logic               last;
    logic               singular;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_C,
    ST_SUB_C,
    ST_MUL_D,
    ST_SUB_D,
    ST_DIV_C,
    ST_WAIT_C,
    ST_DIV_D,
    ST_WAIT_D,
    ST_OUT,
    ST_BS_MUL,
    ST_BS_SUB
  } state_t;

  // saturate a 33-bit difference to 32 bits
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tds_mul.sv =====
// ---------------------------------------------------------------------------
// tds_mul
// Shared fixed-point multiplier: registered 32x32 product, then a floor
// shift by the fraction bits and saturation to 32 bits.
// ---------------------------------------------------------------------------
`default_nettype none

module tds_mul import tds_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire                clk,
  input  wire                en,
  input  wire  signed [31:0] op_a,
  input  wire  signed [31:0] op_b,
  output logic signed [31:0] res
);

  logic signed [63:0] prod_r;
  logic signed [63:0] shifted;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

  // arithmetic shift rounds toward minus infinity
  always_comb begin
    shifted = prod_r >>> FRAC_BITS;
    if (shifted[63:31] != {33{shifted[63]}}) begin
      res = shifted[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      res = shifted[31:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tds_div.sv =====
// ---------------------------------------------------------------------------
// tds_div
// Iterative signed divider, one quotient bit per cycle:
// (num * 2^FRAC_BITS) / den, truncated toward zero, saturated, 0 for den 0.
// ---------------------------------------------------------------------------
`default_nettype none

module tds_div import tds_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire  signed [31:0] num,
  input  wire  signed [31:0] den,
  output logic               busy,
  output logic signed [31:0] quot
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] q_r;      // shifts the dividend out and the quotient in
  logic [31:0]   rem_r;
  logic [31:0]   dmag_r;
  logic          neg_r;
  logic          zero_r;

  logic [32:0]   rem_sh;
  logic          ge;
  logic [31:0]   nmag;
  logic [31:0]   dmag;

  assign nmag = num[31] ? (~num + 32'd1) : num;
  assign dmag = den[31] ? (~den + 32'd1) : den;

  // restoring step
  always_comb begin
    rem_sh = {rem_r, q_r[NW-1]};
    ge     = rem_sh >= {1'b0, dmag_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r    <= {nmag, {FRAC_BITS{1'b0}}};
      rem_r  <= '0;
      dmag_r <= dmag;
      neg_r  <= num[31] ^ den[31];
      zero_r <= (den == 32'sd0);
    end else if (busy_r) begin
      rem_r <= ge ? 32'(rem_sh - {1'b0, dmag_r}) : rem_sh[31:0];
      q_r   <= {q_r[NW-2:0], ge};
    end
  end

  assign busy = busy_r;

  // sign and saturation of the magnitude quotient
  always_comb begin
    if (zero_r) begin
      quot = '0;
    end else if (neg_r) begin
      if ((|q_r[NW-1:32]) || (q_r[31] && (|q_r[30:0]))) begin
        quot = 32'sh8000_0000;
      end else begin
        quot = ~q_r[31:0] + 32'd1;
      end
    end else begin
      if (|q_r[NW-1:31]) begin
        quot = 32'sh7fff_ffff;
      end else begin
        quot = q_r[31:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tridiagonal_solver_core.sv =====
// ---------------------------------------------------------------------------
// tridiagonal_solver_core
// Thomas-algorithm tridiagonal solver, one matrix row per input word.
//
//   channel | dir | word        | handshake
//   in_     | in  | in_word_t   | in_valid / in_stall
//   out_    | out | out_word_t  | out_valid / out_stall
//
// Data words are Q16.16 at the default FRAC_BITS. Each row makes two passes
// through the shared bit-serial divider; row 0 skips the multiply and
// subtract states. After the last row, each solution word but the last is
// followed by back substitution (ST_BS_MUL, ST_BS_SUB) on the shared multiplier.
// Reset is synchronous, active low; the stores are not cleared.
// A stalled output word holds; no new row is taken until row 0 is out.
// ---------------------------------------------------------------------------
`default_nettype none

module tridiagonal_solver_core import tds_pkg::*; #(
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_stall,
  input  wire  in_word_t in_data,
  output logic           out_valid,
  input  wire            out_stall,
  output out_word_t      out_data
);

  `include "tridiagonal_solver_core_assert.svh"

  localparam int IW = $clog2(MAX_ROWS);

  state_t state_r, state_nxt;

  logic signed [31:0] a_r, b_r, c_r, d_r;
  logic               fin_r;
  logic [IW-1:0]      idx_r;
  logic [IW-1:0]      row_count_r;
  logic [IW-1:0]      bs_idx_r;
  logic               pzs_r;
  logic signed [31:0] piv_r, num_r, x_r;
  logic signed [31:0] cp_rd_r, dp_rd_r;

  logic signed [31:0] cp_mem [MAX_ROWS];
  logic signed [31:0] dp_mem [MAX_ROWS];

  logic               in_acc, out_acc;
  logic               rd_en, cp_we, dp_we;
  logic [IW-1:0]      rd_addr;
  logic               mul_en, div_start, div_busy;
  logic signed [31:0] mul_a, mul_b, mul_res, div_num, div_res;
  logic               at_end;
  logic [IW+5:0]      bs_idx_ext;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign at_end  = (row_count_r == IW'(MAX_ROWS - 1));

  // shared units
  tds_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .res  (mul_res)
  );

  tds_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (piv_r),
    .busy  (div_busy),
    .quot  (div_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) begin
                   state_nxt = (row_count_r == '0) ? ST_DIV_C : ST_MUL_C;
                 end
      ST_MUL_C:  state_nxt = ST_SUB_C;
      ST_SUB_C:  state_nxt = ST_MUL_D;
      ST_MUL_D:  state_nxt = ST_SUB_D;
      ST_SUB_D:  state_nxt = ST_DIV_C;
      ST_DIV_C:  state_nxt = ST_WAIT_C;
      ST_WAIT_C: if (!div_busy) state_nxt = ST_DIV_D;
      ST_DIV_D:  state_nxt = ST_WAIT_D;
      ST_WAIT_D: if (!div_busy) state_nxt = fin_r ? ST_OUT : ST_IDLE;
      ST_OUT:    if (out_acc) begin
                   state_nxt = (bs_idx_r == '0) ? ST_IDLE : ST_BS_MUL;
                 end
      ST_BS_MUL: state_nxt = ST_BS_SUB;
      ST_BS_SUB: state_nxt = ST_OUT;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = row_count_r - 1'b1;
    mul_en    = 1'b0;
    mul_a     = a_r;
    mul_b     = cp_rd_r;
    div_start = 1'b0;
    div_num   = c_r;
    cp_we     = 1'b0;
    dp_we     = 1'b0;
    unique case (state_r)
      ST_IDLE:   begin
        in_stall = 1'b0;
        rd_en    = in_valid;
      end
      ST_MUL_C:  mul_en = 1'b1;
      ST_MUL_D:  begin
        mul_en = 1'b1;
        mul_b  = dp_rd_r;
      end
      ST_DIV_C:  div_start = 1'b1;
      ST_WAIT_C: cp_we = !div_busy;
      ST_DIV_D:  begin
        div_start = 1'b1;
        div_num   = num_r;
      end
      ST_WAIT_D: dp_we = !div_busy;
      ST_OUT:    begin
        out_valid = 1'b1;
        rd_en     = out_acc && (bs_idx_r != '0);
        rd_addr   = bs_idx_r - 1'b1;
      end
      ST_BS_MUL: begin
        mul_en = 1'b1;
        mul_a  = cp_rd_r;
        mul_b  = x_r;
      end
      default:   ;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_count_r <= '0;
      pzs_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cp_we && (piv_r == 32'sd0)) begin
        pzs_r <= 1'b1;
      end
      if (dp_we && !fin_r) begin
        row_count_r <= row_count_r + 1'b1;
      end
      if (out_acc && (bs_idx_r == '0)) begin
        row_count_r <= '0;
        pzs_r       <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_r   <= in_data.sub_diag;
      b_r   <= in_data.main_diag;
      c_r   <= in_data.super_diag;
      d_r   <= in_data.rhs;
      fin_r <= in_data.last_row || at_end;
      idx_r <= row_count_r;
      piv_r <= in_data.main_diag;
      num_r <= in_data.rhs;
    end
    if (state_r == ST_SUB_C) begin
      piv_r <= sat33(33'(b_r) - 33'(mul_res));
    end
    if (state_r == ST_SUB_D) begin
      num_r <= sat33(33'(d_r) - 33'(mul_res));
    end
    if (dp_we) begin
      x_r      <= div_res;
      bs_idx_r <= idx_r;
    end
    if (out_acc) begin
      bs_idx_r <= bs_idx_r - 1'b1;
    end
    if (state_r == ST_BS_SUB) begin
      x_r <= sat33(33'(dp_rd_r) - 33'(mul_res));
    end
  end

  // scaled super-diagonal and right-hand side stores
  always_ff @(posedge clk) begin
    if (cp_we) begin
      cp_mem[idx_r] <= div_res;
    end
    if (dp_we) begin
      dp_mem[idx_r] <= div_res;
    end
    if (rd_en) begin
      cp_rd_r <= cp_mem[rd_addr];
      dp_rd_r <= dp_mem[rd_addr];
    end
  end

  // result word
  assign bs_idx_ext         = {6'd0, bs_idx_r};
  assign out_data.solution  = x_r;
  assign out_data.row_index = bs_idx_ext[5:0];
  assign out_data.last      = (bs_idx_r == '0);
  assign out_data.singular  = pzs_r;

  `TDS_ASSERT_NEXT(a_solve_clears, out_acc && out_data.last, (row_count_r == '0) && !pzs_r, "system state not cleared after row 0")
  `TDS_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall, "row taken while busy")
  `TDS_ASSERT_NOW(a_div_idle_at_start, div_start, !div_busy, "divider started while busy")

endmodule

`default_nettype wire

// ===== verif/tb_tridiagonal_solver_core.sv =====
// ----------------------------------------------------------------------------
// tb_tridiagonal_solver_core
// Sends matrix rows to the Thomas-algorithm solver and checks every solution
// word against a fixed-point predictor of the forward sweep and the back
// substitution. The input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module tb_tridiagonal_solver_core;
  import tds_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NROWS = MAX_ROWS_DEF;
  localparam int FB    = FRAC_BITS_DEF;
  localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  tridiagonal_solver_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor state
  logic signed [31:0] cp_store [NROWS];
  logic signed [31:0] dp_store [NROWS];
  int unsigned        rows_taken = 0;
  logic               zero_pivot = 1'b0;
  out_word_t          solution_q[$];
  int                 mismatches = 0;
  int                 stall_left = 0;

  function automatic logic signed [31:0] clamp32(input logic signed [95:0] v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v[31:0];
  endfunction

  // product shifted with floor rounding (arithmetic shift floors)
  function automatic logic signed [31:0] fx_product(input logic signed [31:0] p,
                                                    input logic signed [31:0] q);
    logic signed [95:0] w;
    w = 96'(p) * 96'(q);
    return clamp32(w >>> FB);
  endfunction

  // quotient truncated toward zero; zero divisor gives zero
  function automatic logic signed [31:0] fx_quot(input logic signed [31:0] n,
                                                 input logic signed [31:0] d);
    logic signed [95:0] w;
    if (d == 0) return 0;
    w = (96'(n) <<< FB) / 96'(d);
    return clamp32(w);
  endfunction

  // forward sweep for one row; on the final row push the solution words
  task automatic predict_row(input in_word_t r);
    int unsigned idx;
    logic fin;
    logic signed [31:0] piv, num, x;
    out_word_t o;
    idx = rows_taken;
    fin = r.last_row;
    if (idx >= NROWS - 1) begin
      idx = NROWS - 1;
      fin = 1'b1;
    end
    if (idx == 0) begin
      piv = r.main_diag;
      num = r.rhs;
    end else begin
      piv = clamp32(96'(r.main_diag) - 96'(fx_product(r.sub_diag, cp_store[idx-1])));
      num = clamp32(96'(r.rhs) - 96'(fx_product(r.sub_diag, dp_store[idx-1])));
    end
    if (piv == 0) zero_pivot = 1'b1;
    cp_store[idx] = fx_quot(r.super_diag, piv);
    dp_store[idx] = fx_quot(num, piv);
    if (!fin) begin
      rows_taken = idx + 1;
      return;
    end
    x = dp_store[idx];
    for (int i = idx; i >= 0; i--) begin
      if (i != idx)
        x = clamp32(96'(dp_store[i]) - 96'(fx_product(cp_store[i], x)));
      o.solution  = x;
      o.row_index = 6'(i);
      o.last      = (i == 0);
      o.singular  = zero_pivot;
      solution_q.push_back(o);
    end
    rows_taken = 0;
    zero_pivot = 1'b0;
  endtask

  // send one row word after a random gap; valid stays high with no gap
  task automatic send_row(input in_word_t r);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_row(r);
  endtask

  function automatic in_word_t make_row(input logic signed [31:0] a, b, c, d,
                                        input logic fin);
    in_word_t r;
    r.sub_diag = a; r.main_diag = b; r.super_diag = c; r.rhs = d; r.last_row = fin;
    return r;
  endfunction

  function automatic logic signed [31:0] rnd_small();
    return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
  endfunction

  // diagonally dominant row with random content
  function automatic in_word_t rnd_row(input logic fin);
    logic signed [31:0] b;
    b = $signed($urandom_range(32'h0004_0000, 32'h0008_0000));
    if ($urandom_range(0, 1)) b = -b;
    return make_row(rnd_small(), b, rnd_small(),
                    $signed($urandom_range(0, 32'h00a0_0000)) - 32'sh0050_0000, fin);
  endfunction

  function automatic logic signed [31:0] rnd_full();
    return $signed($urandom());
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (solution_q.size() != 0) @(posedge clk);
  endtask

  // field extremes, single rows, short systems, zero pivot
  task automatic test_directed();
    send_row(make_row(0, 32'sh0001_0000, 0, 32'sh0003_0000, 1'b1));
    send_row(make_row(SMAX, 1, SMIN, SMAX, 1'b1));
    send_row(make_row(SMIN, -1, SMAX, SMIN, 1'b1));
    send_row(make_row(0, 0, 32'sh0001_0000, 32'sh0001_0000, 1'b1));
    send_row(make_row(SMAX, SMIN, SMAX, SMIN, 1'b0));
    send_row(make_row(SMIN, SMAX, SMIN, SMAX, 1'b0));
    send_row(make_row(-1, 1, -1, 1, 1'b1));
    send_row(make_row(32'sh0001_0000, 0, 32'sh0001_0000, 32'sh0002_0000, 1'b0));
    send_row(make_row(32'sh0001_0000, 32'sh0002_0000, 0, 32'sh0002_0000, 1'b1));
    send_row(make_row(32'sh0001_0000, 32'sh0004_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b0));
    send_row(make_row(32'sh0001_0000, 32'sh0004_0000, 32'sh0001_0000, 32'sh0002_0000, 1'b0));
    send_row(make_row(32'sh0001_0000, 32'sh0004_0000, 0, 32'sh0003_0000, 1'b1));
  endtask

  // a system that fills the row limit; solving is forced at the last slot
  task automatic test_row_limit();
    for (int i = 0; i < NROWS; i++) send_row(rnd_row(1'b0));
  endtask

  // random systems, mostly well conditioned, some full-range noise
  task automatic test_random();
    int len;
    in_word_t r;
    for (int s = 0; s < 5; s++) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 4) == 0)
          r = make_row(rnd_full(), rnd_full(), rnd_full(), rnd_full(), 1'b0);
        else
          r = rnd_row(1'b0);
        r.last_row = (i == len - 1);
        send_row(r);
      end
      if (s == 2) wait_drained();
    end
  endtask

  // result checking; a stall length is drawn for every word taken
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (solution_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", out_data);
      end else begin
        e = solution_q.pop_front();
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", e, out_data);
        end
      end
      stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left != 0);
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_row_limit();
    test_random();
    wait_drained();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && solution_q.size() == 0)
      $display("PASS tridiagonal_solver_core");
    else
      $display("FAIL tridiagonal_solver_core");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL tridiagonal_solver_core");
    $finish;
  end

endmodule
